@@ rtl/core/ptstc_pkg.sv @@
`timescale 1ns / 1ps

package ptstc_pkg;

    // image geometry
    localparam int IMAGE_WIDTH  = 320;
    localparam int IMAGE_HEIGHT = 240;
    localparam logic signed [10:0] X_HALF = 11'(IMAGE_WIDTH / 2);
    localparam logic signed [10:0] Y_HALF = 11'(IMAGE_HEIGHT / 2);

    // tracking, thresholds packed lowest first
    localparam logic [9:0] PAN_DEADBAND = 10'd15;
    localparam int PAN_THR_N  = 12;
    localparam int TILT_THR_N = 6;
    localparam logic [PAN_THR_N*10-1:0] PAN_THR = {
        10'd472, 10'd423, 10'd376, 10'd332, 10'd291, 10'd251,
        10'd213, 10'd176, 10'd139, 10'd104, 10'd69, 10'd35
    };
    localparam logic [TILT_THR_N*10-1:0] TILT_THR = {
        10'd472, 10'd376, 10'd291, 10'd213, 10'd139, 10'd69
    };

    // speeds and offsets
    localparam logic [8:0] SPEED_SCAN  = 9'd300;
    localparam logic [8:0] SPEED_TRACK = 9'd250;
    localparam logic [8:0] SPEED_HOME  = 9'd200;
    localparam logic [10:0] PAN_PACKET_OFFSET = 11'd65;
    localparam logic [9:0] POS_MAX = 10'd1023;

    // scan pattern
    localparam logic [2:0] STEP_FIRST = 3'd1;
    localparam logic [2:0] STEP_LAST  = 3'd7;

    // packet layout
    localparam int PKT_LEN = 18;
    localparam int IDX_W   = $clog2(PKT_LEN);
    localparam logic [7:0] PKT_HDR      = 8'hFF;
    localparam logic [7:0] PKT_BCAST_ID = 8'hFE;
    localparam logic [7:0] PKT_LENGTH   = 8'h0E;
    localparam logic [7:0] PKT_SYNC_WR  = 8'h83;
    localparam logic [7:0] PKT_ADDR     = 8'h1E;
    localparam logic [7:0] PKT_DATA_LEN = 8'h04;

    // descriptor queue
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    typedef enum logic [2:0] {
        MODE_SCAN       = 3'd0,
        MODE_VIEW_LEFT  = 3'd1,
        MODE_VIEW_RIGHT = 3'd2,
        MODE_VIEW_DOWN  = 3'd3,
        MODE_KICK_VIEW  = 3'd4,
        MODE_HOME       = 3'd5
    } mode_t;

    typedef enum logic [2:0] {
        CFG_PAN_CENTER   = 3'd0,
        CFG_PAN_LEFT     = 3'd1,
        CFG_PAN_RIGHT    = 3'd2,
        CFG_TILT_TOP     = 3'd3,
        CFG_TILT_BOTTOM  = 3'd4,
        CFG_DWELL_MS     = 3'd5,
        CFG_TILT_ID      = 3'd6,
        CFG_PAN_ID       = 3'd7
    } cfg_idx_t;

    typedef struct packed {
        logic [9:0]  pan_center;
        logic [9:0]  pan_left_limit;
        logic [9:0]  pan_right_limit;
        logic [9:0]  tilt_top_limit;
        logic [9:0]  tilt_bottom_limit;
        logic [15:0] dwell_ms;
        logic [7:0]  tilt_servo_id;
        logic [7:0]  pan_servo_id;
    } cfg_t;

    // one packet to send
    typedef struct packed {
        logic [9:0]  tilt;
        logic [10:0] pan_cmd;
        logic [8:0]  speed;
        logic        capture;
    } desc_t;

    function automatic logic [9:0] sat10(input logic signed [11:0] v);
        logic [9:0] r;
        if (v < 12'sd0) begin
            r = '0;
        end else if (v > $signed({2'b00, POS_MAX})) begin
            r = POS_MAX;
        end else begin
            r = v[9:0];
        end
        return r;
    endfunction

    function automatic logic [3:0] pan_steps(input logic [9:0] mag);
        logic [3:0] c;
        c = '0;
        for (int i = 0; i < PAN_THR_N; i++) begin
            if (mag >= PAN_THR[i*10 +: 10]) begin
                c = c + 4'd1;
            end
        end
        return c;
    endfunction

    function automatic logic [3:0] tilt_steps(input logic [9:0] mag);
        logic [3:0] c;
        c = '0;
        for (int i = 0; i < TILT_THR_N; i++) begin
            if (mag >= TILT_THR[i*10 +: 10]) begin
                c = c + 4'd1;
            end
        end
        return c;
    endfunction

endpackage

@@ rtl/core/ptstc_front.sv @@
`timescale 1ns / 1ps

module ptstc_front import ptstc_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  cfg_t        cfg,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_mode,
    input  logic        s_ball_found,
    input  logic        s_capture_done,
    input  logic [8:0]  s_ball_x,
    input  logic [7:0]  s_ball_y,
    input  logic [31:0] s_time_ms,
    input  logic        q_full,
    output logic        q_push,
    output desc_t       q_data
);

    logic [9:0]  pan_reg, pan_next;
    logic [9:0]  tilt_reg, tilt_next;
    logic [2:0]  step_reg, step_next;
    logic [8:0]  speed_reg, speed_next;
    logic        rearm_reg, rearm_next;
    logic [31:0] start_reg, start_next;
    logic        cap_reg, cap_next;

    logic signed [11:0] center_s, left_s, right_s, top_s, bottom_s;
    logic signed [10:0] dx, dy;
    logic [9:0]  dx_mag, dy_mag;
    logic [3:0]  pan_cnt, tilt_cnt;
    logic signed [11:0] pan_corr, tilt_corr, pan_v, tilt_v;
    logic [31:0] elapsed;
    logic        step_ok;
    logic [9:0]  scan_pan, scan_tilt;
    logic        accept;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;

    assign center_s = $signed({2'b00, cfg.pan_center});
    assign left_s   = $signed({2'b00, cfg.pan_left_limit});
    assign right_s  = $signed({2'b00, cfg.pan_right_limit});
    assign top_s    = $signed({2'b00, cfg.tilt_top_limit});
    assign bottom_s = $signed({2'b00, cfg.tilt_bottom_limit});

    // ball offsets from image center
    assign dx     = $signed({2'b00, s_ball_x}) - X_HALF;
    assign dy     = Y_HALF - $signed({3'b000, s_ball_y});
    assign dx_mag = dx[10] ? 10'(-dx) : dx[9:0];
    assign dy_mag = dy[10] ? 10'(-dy) : dy[9:0];
    assign pan_cnt  = pan_steps(dx_mag);
    assign tilt_cnt = tilt_steps(dy_mag);
    assign pan_corr  = dx[10] ? -$signed({8'b0, pan_cnt})  : $signed({8'b0, pan_cnt});
    assign tilt_corr = dy[10] ? -$signed({8'b0, tilt_cnt}) : $signed({8'b0, tilt_cnt});

    assign elapsed = s_time_ms - start_reg;

    always_comb begin
        step_ok   = 1'b1;
        scan_pan  = pan_reg;
        scan_tilt = tilt_reg;
        case (step_reg)
            3'd1: begin scan_pan = cfg.pan_right_limit; scan_tilt = cfg.tilt_bottom_limit; end
            3'd2: begin scan_pan = cfg.pan_center;      scan_tilt = cfg.tilt_bottom_limit; end
            3'd3: begin scan_pan = cfg.pan_left_limit;  scan_tilt = cfg.tilt_bottom_limit; end
            3'd4: begin scan_pan = cfg.pan_left_limit;  scan_tilt = cfg.tilt_top_limit; end
            3'd5: begin scan_pan = cfg.pan_center;      scan_tilt = cfg.tilt_top_limit; end
            3'd6: begin scan_pan = cfg.pan_right_limit; scan_tilt = cfg.tilt_top_limit; end
            3'd7: begin
                scan_pan  = cfg.pan_center;
                scan_tilt = sat10(bottom_s - 12'sd50);
            end
            default: step_ok = 1'b0;
        endcase
    end

    always_comb begin
        pan_next   = pan_reg;
        tilt_next  = tilt_reg;
        step_next  = step_reg;
        speed_next = speed_reg;
        rearm_next = rearm_reg;
        start_next = start_reg;
        cap_next   = cap_reg;
        tilt_v     = '0;
        pan_v      = '0;
        case (mode_t'(s_mode))
            MODE_SCAN: begin
                if (s_ball_found) begin
                    cap_next   = 1'b1;
                    speed_next = SPEED_TRACK;
                    tilt_v = $signed({2'b00, tilt_reg}) - tilt_corr;
                    if (tilt_v < top_s) tilt_v = top_s;
                    if (tilt_v > bottom_s) tilt_v = bottom_s;
                    tilt_next = sat10(tilt_v);
                    if (dx_mag > PAN_DEADBAND) begin
                        pan_v = $signed({2'b00, pan_reg}) - pan_corr;
                        if (pan_v > right_s) pan_v = right_s;
                        else if (pan_v < left_s) pan_v = left_s;
                        pan_next = sat10(pan_v);
                    end
                end else begin
                    speed_next = SPEED_SCAN;
                    if (step_ok) begin
                        pan_next  = scan_pan;
                        tilt_next = scan_tilt;
                        if (rearm_reg) begin
                            start_next = s_time_ms;
                            rearm_next = 1'b0;
                        end else if (elapsed > {16'b0, cfg.dwell_ms}) begin
                            start_next = s_time_ms;
                            cap_next   = 1'b1;
                            if (s_capture_done) begin
                                step_next  = (step_reg >= STEP_LAST) ? STEP_FIRST
                                                                     : step_reg + 3'd1;
                                cap_next   = 1'b0;
                                rearm_next = 1'b1;
                            end
                        end
                    end
                end
            end
            MODE_VIEW_LEFT: begin
                pan_next  = sat10(center_s + 12'sd70);
                tilt_next = sat10(bottom_s - 12'sd10);
            end
            MODE_VIEW_RIGHT: begin
                pan_next  = sat10(center_s - 12'sd60);
                tilt_next = sat10(bottom_s - 12'sd10);
            end
            MODE_VIEW_DOWN: begin
                cap_next  = 1'b1;
                pan_next  = cfg.pan_center;
                tilt_next = cfg.tilt_top_limit;
            end
            MODE_KICK_VIEW: begin
                cap_next  = 1'b1;
                pan_next  = cfg.pan_center;
                tilt_next = sat10(top_s + 12'sd10);
            end
            MODE_HOME: begin
                pan_next   = cfg.pan_center;
                tilt_next  = sat10(top_s + 12'sd10);
                speed_next = SPEED_HOME;
                step_next  = STEP_FIRST;
                rearm_next = 1'b1;
                cap_next   = 1'b0;
            end
            default: ;
        endcase
    end

    assign q_push          = accept;
    assign q_data.tilt     = tilt_next;
    assign q_data.pan_cmd  = {1'b0, pan_next} + PAN_PACKET_OFFSET;
    assign q_data.speed    = speed_next;
    assign q_data.capture  = cap_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pan_reg   <= '0;
            tilt_reg  <= '0;
            step_reg  <= STEP_FIRST;
            speed_reg <= SPEED_HOME;
            rearm_reg <= 1'b1;
            start_reg <= '0;
            cap_reg   <= 1'b0;
        end else if (accept) begin
            pan_reg   <= pan_next;
            tilt_reg  <= tilt_next;
            step_reg  <= step_next;
            speed_reg <= speed_next;
            rearm_reg <= rearm_next;
            start_reg <= start_next;
            cap_reg   <= cap_next;
        end
    end

endmodule

@@ rtl/core/ptstc_queue.sv @@
`timescale 1ns / 1ps

module ptstc_queue import ptstc_pkg::*; (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  push,
    input  desc_t push_data,
    output logic  full,
    input  logic  pop,
    output desc_t pop_data,
    output logic  not_empty
);

    desc_t mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QUEUE_AW:0]   count_reg, count_next;
    logic do_push, do_pop;

    assign full      = (count_reg == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign pop_data  = mem[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (do_push && !do_pop) count_next = count_reg + 1'b1;
        if (do_pop && !do_push) count_next = count_reg - 1'b1;
    end

    function automatic logic [QUEUE_AW-1:0] ptr_inc(input logic [QUEUE_AW-1:0] p);
        logic [QUEUE_AW-1:0] r;
        if (p == (QUEUE_AW)'(QUEUE_DEPTH - 1)) r = '0;
        else r = p + 1'b1;
        return r;
    endfunction

    always_ff @(posedge aclk) begin
        if (do_push) mem[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            if (do_pop)  rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            count_reg <= count_next;
        end
    end

endmodule

@@ rtl/core/ptstc_back.sv @@
`timescale 1ns / 1ps

module ptstc_back import ptstc_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  cfg_t       cfg,
    input  logic       q_not_empty,
    input  desc_t      q_data,
    output logic       q_pop,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_packet_byte,
    output logic       m_last_byte,
    output logic       m_capture_request
);

    desc_t            cur_reg;
    logic             active_reg, active_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [7:0]       sum_reg, sum_next;
    logic             out_valid_reg, out_valid_next;
    logic [7:0]       out_byte_reg;
    logic             out_last_reg, out_cap_reg;
    logic             load, emit, last_idx;
    logic [7:0]       byte_sel;

    assign load     = !out_valid_reg || m_ready;
    assign emit     = active_reg && load;
    assign last_idx = (idx_reg == IDX_W'(PKT_LEN - 1));
    assign q_pop    = q_not_empty && (!active_reg || (emit && last_idx));

    always_comb begin
        case (idx_reg)
            5'd0, 5'd1: byte_sel = PKT_HDR;
            5'd2:       byte_sel = PKT_BCAST_ID;
            5'd3:       byte_sel = PKT_LENGTH;
            5'd4:       byte_sel = PKT_SYNC_WR;
            5'd5:       byte_sel = PKT_ADDR;
            5'd6:       byte_sel = PKT_DATA_LEN;
            5'd7:       byte_sel = cfg.tilt_servo_id;
            5'd8:       byte_sel = cur_reg.tilt[7:0];
            5'd9:       byte_sel = {6'b0, cur_reg.tilt[9:8]};
            5'd10:      byte_sel = cur_reg.speed[7:0];
            5'd11:      byte_sel = {7'b0, cur_reg.speed[8]};
            5'd12:      byte_sel = cfg.pan_servo_id;
            5'd13:      byte_sel = cur_reg.pan_cmd[7:0];
            5'd14:      byte_sel = {5'b0, cur_reg.pan_cmd[10:8]};
            5'd15:      byte_sel = cur_reg.speed[7:0];
            5'd16:      byte_sel = {7'b0, cur_reg.speed[8]};
            default:    byte_sel = ~sum_reg;
        endcase
    end

    always_comb begin
        active_next    = active_reg;
        idx_next       = idx_reg;
        sum_next       = sum_reg;
        out_valid_next = out_valid_reg && !m_ready;
        if (emit) begin
            out_valid_next = 1'b1;
            // checksum covers the bytes after the two header bytes, up to the checksum byte
            if (idx_reg < 5'd2) sum_next = '0;
            else if (!last_idx) sum_next = sum_reg + byte_sel;
            if (last_idx) begin
                idx_next    = '0;
                active_next = 1'b0;
            end else begin
                idx_next = idx_reg + 1'b1;
            end
        end
        if (q_pop) begin
            active_next = 1'b1;
            idx_next    = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) cur_reg <= q_data;
        if (emit) begin
            out_byte_reg <= byte_sel;
            out_last_reg <= last_idx;
            out_cap_reg  <= cur_reg.capture;
        end
        sum_reg <= sum_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg    <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            active_reg    <= active_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_valid           = out_valid_reg;
    assign m_packet_byte     = out_byte_reg;
    assign m_last_byte       = out_last_reg;
    assign m_capture_request = out_cap_reg;

endmodule

@@ rtl/core/pan_tilt_scan_track_controller.sv @@
`timescale 1ns / 1ps

// Pan/tilt head controller: every accepted request is one control call (scan or track,
// a fixed view, or home) and produces one 18-byte servo sync-write packet, sent one
// byte per cycle on the m_ channel while m_ready is high, with m_last_byte on the
// checksum byte. The front end updates the head state and takes a request every cycle
// while the two-entry packet queue has room; the serializer finishes each packet before
// it takes the next and so sets the sustained rate. Configuration writes are taken at
// any time on the cfg channel but must only be issued while no packet is pending.

module pan_tilt_scan_track_controller import ptstc_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    // control call requests
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_mode,
    input  logic        s_ball_found,
    input  logic        s_capture_done,
    input  logic [8:0]  s_ball_x,
    input  logic [7:0]  s_ball_y,
    input  logic [31:0] s_time_ms,
    // packet bytes
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_packet_byte,
    output logic        m_last_byte,
    output logic        m_capture_request
);

    cfg_t  cfg_reg;
    logic  q_push, q_full, q_pop, q_not_empty;
    desc_t q_in, q_out;

    // configuration registers, always ready
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.pan_center        <= 10'd512;
            cfg_reg.pan_left_limit    <= 10'd200;
            cfg_reg.pan_right_limit   <= 10'd824;
            cfg_reg.tilt_top_limit    <= 10'd300;
            cfg_reg.tilt_bottom_limit <= 10'd700;
            cfg_reg.dwell_ms          <= 16'd500;
            cfg_reg.tilt_servo_id     <= 8'd1;
            cfg_reg.pan_servo_id      <= 8'd2;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_idx_t'(cfg_index))
                CFG_PAN_CENTER:  cfg_reg.pan_center        <= cfg_data[9:0];
                CFG_PAN_LEFT:    cfg_reg.pan_left_limit    <= cfg_data[9:0];
                CFG_PAN_RIGHT:   cfg_reg.pan_right_limit   <= cfg_data[9:0];
                CFG_TILT_TOP:    cfg_reg.tilt_top_limit    <= cfg_data[9:0];
                CFG_TILT_BOTTOM: cfg_reg.tilt_bottom_limit <= cfg_data[9:0];
                CFG_DWELL_MS:    cfg_reg.dwell_ms          <= cfg_data;
                CFG_TILT_ID:     cfg_reg.tilt_servo_id     <= cfg_data[7:0];
                CFG_PAN_ID:      cfg_reg.pan_servo_id      <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // front end: head state, scan sequencing and tracking corrections
    ptstc_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg            (cfg_reg),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_mode         (s_mode),
        .s_ball_found   (s_ball_found),
        .s_capture_done (s_capture_done),
        .s_ball_x       (s_ball_x),
        .s_ball_y       (s_ball_y),
        .s_time_ms      (s_time_ms),
        .q_full         (q_full),
        .q_push         (q_push),
        .q_data         (q_in)
    );

    // packet descriptors waiting to be serialized
    ptstc_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_out),
        .not_empty (q_not_empty)
    );

    // back end: byte serializer with running checksum and output register
    ptstc_back u_back (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg               (cfg_reg),
        .q_not_empty       (q_not_empty),
        .q_data            (q_out),
        .q_pop             (q_pop),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_packet_byte     (m_packet_byte),
        .m_last_byte       (m_last_byte),
        .m_capture_request (m_capture_request)
    );

endmodule

@@ sim/pan_tilt_scan_track_controller_test.sv @@
`timescale 1ns / 1ps

module pan_tilt_scan_track_controller_test;
    import ptstc_pkg::*;

    // run control
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int TAIL_CYCLES     = 40;
    localparam int RANDOM_PHASES   = 8;
    localparam int CALLS_PER_PHASE = 32;
    localparam int EXTREME_CALLS   = 30;

    // mode codes the package leaves unnamed, the head must ignore them
    localparam logic [2:0] MODE_RSVD6 = 3'd6;
    localparam logic [2:0] MODE_RSVD7 = 3'd7;

    // servo packet framing
    localparam int         PACKET_BYTES = 18;
    localparam logic [7:0] SYNC_BYTE    = 8'hFF;
    localparam logic [7:0] BCAST_ID     = 8'hFE;
    localparam logic [7:0] BODY_LEN     = 8'h0E;
    localparam logic [7:0] SYNC_WRITE   = 8'h83;
    localparam logic [7:0] GOAL_ADDR    = 8'h1E;
    localparam logic [7:0] PER_SERVO    = 8'h04;

    // head behavior
    localparam logic [8:0]  SCAN_SPEED  = 9'd300;
    localparam logic [8:0]  TRACK_SPEED = 9'd250;
    localparam logic [8:0]  HOME_SPEED  = 9'd200;
    localparam logic [10:0] PAN_OFFSET  = 11'd65;
    localparam int DEADBAND = 15;
    localparam int X_MID    = 160;
    localparam int Y_MID    = 120;

    // |offset| at which each further correction step kicks in, lowest first
    localparam logic [119:0] PAN_KNEES = {10'd472, 10'd423, 10'd376, 10'd332,
                                          10'd291, 10'd251, 10'd213, 10'd176,
                                          10'd139, 10'd104, 10'd69,  10'd35};
    localparam logic [59:0]  TILT_KNEES = {10'd472, 10'd376, 10'd291,
                                           10'd213, 10'd139, 10'd69};

    // one control call as presented on the s_ channel
    typedef struct packed {
        logic [2:0]  mode;
        logic        ball;
        logic        cap_done;
        logic [8:0]  bx;
        logic [7:0]  by;
        logic [31:0] stamp;
    } call_t;

    // one byte of a servo packet as seen on the m_ channel
    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       capture;
    } packet_byte_t;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [15:0] cfg_data;
    logic        s_valid;
    logic        s_ready;
    logic [2:0]  s_mode;
    logic        s_ball_found;
    logic        s_capture_done;
    logic [8:0]  s_ball_x;
    logic [7:0]  s_ball_y;
    logic [31:0] s_time_ms;
    logic        m_valid;
    logic        m_ready;
    logic [7:0]  m_packet_byte;
    logic        m_last_byte;
    logic        m_capture_request;

    // shadow of the register file and of the head state
    cfg_t        regs;
    logic [9:0]  head_pan;
    logic [9:0]  head_tilt;
    logic [2:0]  scan_idx;
    logic [8:0]  servo_speed;
    logic        dwell_rearm;
    logic [31:0] dwell_start;
    logic        capture_pending;

    // packet bytes still owed by the block, oldest first
    packet_byte_t expected_bytes [$];

    // stimulus bookkeeping
    logic [31:0] clock_ms;
    logic        no_idle;
    logic [7:0]  steps_seen;
    int          errors;
    int          calls_sent;
    int          bytes_seen;
    int          reg_writes;
    int          quiet_cycles;

    pan_tilt_scan_track_controller dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_mode            (s_mode),
        .s_ball_found      (s_ball_found),
        .s_capture_done    (s_capture_done),
        .s_ball_x          (s_ball_x),
        .s_ball_y          (s_ball_y),
        .s_time_ms         (s_time_ms),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_packet_byte     (m_packet_byte),
        .m_last_byte       (m_last_byte),
        .m_capture_request (m_capture_request)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // head model
    // ------------------------------------------------------------------

    // positions saturate to the 10-bit servo range
    function automatic logic [9:0] clip_pos(input int v);
        if (v < 0) begin
            return 10'd0;
        end
        if (v > 1023) begin
            return 10'd1023;
        end
        return 10'(v);
    endfunction

    // odd step function: count knees at or below |d|, keep the sign of d
    function automatic int knee_count(input int d, input logic [119:0] knees, input int n);
        int mag;
        int steps;
        mag = (d < 0) ? -d : d;
        steps = 0;
        for (int i = 0; i < n; i++) begin
            if (mag >= int'(knees[i*10 +: 10])) begin
                steps++;
            end
        end
        return (d < 0) ? -steps : steps;
    endfunction

    task automatic reset_head_model();
        regs = '{pan_center: 10'd512, pan_left_limit: 10'd200, pan_right_limit: 10'd824,
                 tilt_top_limit: 10'd300, tilt_bottom_limit: 10'd700, dwell_ms: 16'd500,
                 tilt_servo_id: 8'd1, pan_servo_id: 8'd2};
        head_pan        = '0;
        head_tilt       = '0;
        scan_idx        = 3'd1;
        servo_speed     = HOME_SPEED;
        dwell_rearm     = 1'b1;
        dwell_start     = '0;
        capture_pending = 1'b0;
    endtask

    // scan pattern step: go to the step target, then wait out the dwell
    task automatic scan_dwell(input logic cap_done, input logic [31:0] stamp);
        int   pan_t;
        int   tilt_t;
        int   center_v;
        int   left_v;
        int   right_v;
        int   top_v;
        int   bottom_v;
        logic fired;
        servo_speed = SCAN_SPEED;
        fired = 1'b0;
        center_v = int'(regs.pan_center);
        left_v   = int'(regs.pan_left_limit);
        right_v  = int'(regs.pan_right_limit);
        top_v    = int'(regs.tilt_top_limit);
        bottom_v = int'(regs.tilt_bottom_limit);
        case (scan_idx)
            3'd1: begin pan_t = right_v;  tilt_t = bottom_v; end
            3'd2: begin pan_t = center_v; tilt_t = bottom_v; end
            3'd3: begin pan_t = left_v;   tilt_t = bottom_v; end
            3'd4: begin pan_t = left_v;   tilt_t = top_v;    end
            3'd5: begin pan_t = center_v; tilt_t = top_v;    end
            3'd6: begin pan_t = right_v;  tilt_t = top_v;    end
            3'd7: begin
                pan_t  = center_v;
                tilt_t = bottom_v - 50;
            end
            default: return;
        endcase
        head_pan  = clip_pos(pan_t);
        head_tilt = clip_pos(tilt_t);
        steps_seen[scan_idx] = 1'b1;
        // first call of a step only starts the timer
        if (dwell_rearm) begin
            dwell_start = stamp;
            dwell_rearm = 1'b0;
        end else if (stamp - dwell_start > {16'd0, regs.dwell_ms}) begin
            dwell_start = stamp;
            fired = 1'b1;
        end
        // capture done only counts once the dwell has expired
        if (fired) begin
            capture_pending = 1'b1;
            if (cap_done) begin
                scan_idx        = (scan_idx >= 3'd7) ? 3'd1 : scan_idx + 3'd1;
                capture_pending = 1'b0;
                dwell_rearm     = 1'b1;
            end
        end
    endtask

    // nudge the head toward the ball, tilt always, pan outside the deadband
    task automatic track_ball(input logic [8:0] bx, input logic [7:0] by);
        int dx;
        int dy;
        int v;
        dx = int'(bx) - X_MID;
        dy = Y_MID - int'(by);
        capture_pending = 1'b1;
        servo_speed = TRACK_SPEED;
        // top clamp first, so crossed limits end at bottom
        v = int'(head_tilt) - knee_count(dy, {60'd0, TILT_KNEES}, 6);
        if (v < int'(regs.tilt_top_limit)) begin
            v = int'(regs.tilt_top_limit);
        end
        if (v > int'(regs.tilt_bottom_limit)) begin
            v = int'(regs.tilt_bottom_limit);
        end
        head_tilt = clip_pos(v);
        // right clamp wins over left when limits cross
        if (dx > DEADBAND || dx < -DEADBAND) begin
            v = int'(head_pan) - knee_count(dx, PAN_KNEES, 12);
            if (v > int'(regs.pan_right_limit)) begin
                v = int'(regs.pan_right_limit);
            end else if (v < int'(regs.pan_left_limit)) begin
                v = int'(regs.pan_left_limit);
            end
            head_pan = clip_pos(v);
        end
    endtask

    // update the head for one call and queue the packet it must produce
    task automatic predict_packet(input call_t c);
        logic [7:0]   pkt [PACKET_BYTES];
        logic [10:0]  pan_word;
        logic [7:0]   sum;
        packet_byte_t b;
        case (c.mode)
            MODE_SCAN: begin
                if (c.ball) begin
                    track_ball(c.bx, c.by);
                end else begin
                    scan_dwell(c.cap_done, c.stamp);
                end
            end
            MODE_VIEW_LEFT: begin
                head_pan  = clip_pos(int'(regs.pan_center) + 70);
                head_tilt = clip_pos(int'(regs.tilt_bottom_limit) - 10);
            end
            MODE_VIEW_RIGHT: begin
                head_pan  = clip_pos(int'(regs.pan_center) - 60);
                head_tilt = clip_pos(int'(regs.tilt_bottom_limit) - 10);
            end
            MODE_VIEW_DOWN: begin
                capture_pending = 1'b1;
                head_pan  = regs.pan_center;
                head_tilt = regs.tilt_top_limit;
            end
            MODE_KICK_VIEW: begin
                capture_pending = 1'b1;
                head_pan  = regs.pan_center;
                head_tilt = clip_pos(int'(regs.tilt_top_limit) + 10);
            end
            MODE_HOME: begin
                head_pan        = regs.pan_center;
                head_tilt       = clip_pos(int'(regs.tilt_top_limit) + 10);
                servo_speed     = HOME_SPEED;
                scan_idx        = 3'd1;
                dwell_rearm     = 1'b1;
                capture_pending = 1'b0;
            end
            default: ;
        endcase

        // sync write: tilt servo entry then pan servo entry, pan sent with offset
        pan_word = {1'b0, head_pan} + PAN_OFFSET;
        pkt[0]  = SYNC_BYTE;
        pkt[1]  = SYNC_BYTE;
        pkt[2]  = BCAST_ID;
        pkt[3]  = BODY_LEN;
        pkt[4]  = SYNC_WRITE;
        pkt[5]  = GOAL_ADDR;
        pkt[6]  = PER_SERVO;
        pkt[7]  = regs.tilt_servo_id;
        pkt[8]  = head_tilt[7:0];
        pkt[9]  = {6'd0, head_tilt[9:8]};
        pkt[10] = servo_speed[7:0];
        pkt[11] = {7'd0, servo_speed[8]};
        pkt[12] = regs.pan_servo_id;
        pkt[13] = pan_word[7:0];
        pkt[14] = {5'd0, pan_word[10:8]};
        pkt[15] = pkt[10];
        pkt[16] = pkt[11];
        sum = '0;
        for (int i = 2; i < PACKET_BYTES - 1; i++) begin
            sum = sum + pkt[i];
        end
        pkt[PACKET_BYTES - 1] = ~sum;

        for (int i = 0; i < PACKET_BYTES; i++) begin
            b.data    = pkt[i];
            b.last    = (i == PACKET_BYTES - 1);
            b.capture = capture_pending;
            expected_bytes.push_back(b);
        end
    endtask

    // ------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------

    // idle cycles before the next request, none during burst stretches
    function automatic int pick_gap();
        if (no_idle) begin
            return 0;
        end
        return ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 16);
    endfunction

    function automatic call_t make_call(input logic [2:0] mode, input logic ball,
                                        input logic cap_done, input logic [8:0] bx,
                                        input logic [7:0] by, input logic [31:0] stamp);
        call_t c;
        c.mode     = mode;
        c.ball     = ball;
        c.cap_done = cap_done;
        c.bx       = bx;
        c.by       = by;
        c.stamp    = stamp;
        return c;
    endfunction

    // valid stays up across back-to-back calls, only dropped for a gap
    task automatic issue_call(input call_t c);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_mode         <= c.mode;
        s_ball_found   <= c.ball;
        s_capture_done <= c.cap_done;
        s_ball_x       <= c.bx;
        s_ball_y       <= c.by;
        s_time_ms      <= c.stamp;
        predict_packet(c);
        calls_sent++;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [15:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        case (idx)
            CFG_PAN_CENTER:  regs.pan_center        = value[9:0];
            CFG_PAN_LEFT:    regs.pan_left_limit    = value[9:0];
            CFG_PAN_RIGHT:   regs.pan_right_limit   = value[9:0];
            CFG_TILT_TOP:    regs.tilt_top_limit    = value[9:0];
            CFG_TILT_BOTTOM: regs.tilt_bottom_limit = value[9:0];
            CFG_DWELL_MS:    regs.dwell_ms          = value;
            CFG_TILT_ID:     regs.tilt_servo_id     = value[7:0];
            CFG_PAN_ID:      regs.pan_servo_id      = value[7:0];
            default: ;
        endcase
        reg_writes++;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    // stop calling and let every owed packet byte come out
    task automatic drain_packets();
        s_valid <= 1'b0;
        while (expected_bytes.size() != 0) @(posedge aclk);
    endtask

    // registers only change with the block idle
    task automatic load_setting(input cfg_t s);
        drain_packets();
        write_reg(CFG_PAN_CENTER,  16'(s.pan_center));
        write_reg(CFG_PAN_LEFT,    16'(s.pan_left_limit));
        write_reg(CFG_PAN_RIGHT,   16'(s.pan_right_limit));
        write_reg(CFG_TILT_TOP,    16'(s.tilt_top_limit));
        write_reg(CFG_TILT_BOTTOM, 16'(s.tilt_bottom_limit));
        write_reg(CFG_DWELL_MS,    s.dwell_ms);
        write_reg(CFG_TILT_ID,     16'(s.tilt_servo_id));
        write_reg(CFG_PAN_ID,      16'(s.pan_servo_id));
        cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // random stimulus
    // ------------------------------------------------------------------

    function automatic logic [8:0] random_x();
        case ($urandom_range(0, 7))
            0: return 9'd0;
            1: return 9'd319;
            2: return 9'(X_MID + DEADBAND);
            3: return 9'(X_MID - DEADBAND - 1);
            default: return 9'($urandom_range(0, 319));
        endcase
    endfunction

    function automatic logic [7:0] random_y();
        case ($urandom_range(0, 5))
            0: return 8'd0;
            1: return 8'd239;
            2: return 8'(Y_MID);
            default: return 8'($urandom_range(0, 239));
        endcase
    endfunction

    function automatic cfg_t random_setting();
        cfg_t s;
        s.pan_center      = 10'($urandom_range(0, 1023));
        s.pan_left_limit  = 10'($urandom_range(0, 700));
        s.pan_right_limit = 10'($urandom_range(s.pan_left_limit, 1023));
        s.tilt_top_limit  = 10'($urandom_range(0, 700));
        s.tilt_bottom_limit = 10'($urandom_range(s.tilt_top_limit, 1023));
        // now and then let the limits cross
        if ($urandom_range(0, 3) == 0) begin
            s.pan_left_limit    = 10'($urandom_range(0, 1023));
            s.tilt_bottom_limit = 10'($urandom_range(0, 1023));
        end
        s.dwell_ms = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 65535))
                                                 : 16'($urandom_range(0, 1500));
        s.tilt_servo_id = 8'($urandom_range(0, 253));
        s.pan_servo_id  = 8'($urandom_range(0, 253));
        return s;
    endfunction

    // kinds 0-4 scan runs, 5-6 tracking, 7 views/home, 8 noise, 9 ball flicker
    function automatic call_t random_call(input int kind);
        call_t       c;
        logic [31:0] delta;
        // time steps straddle the dwell so steps advance and also fall short
        case ($urandom_range(0, 3))
            0: delta = $urandom_range(0, regs.dwell_ms);
            1: delta = {16'd0, regs.dwell_ms} + $urandom_range(0, 1);
            2: delta = {16'd0, regs.dwell_ms} + $urandom_range(1, 2000);
            default: delta = $urandom;
        endcase
        clock_ms = clock_ms + delta;
        c = make_call(MODE_SCAN, 1'b0, $urandom_range(0, 3) != 0,
                      random_x(), random_y(), clock_ms);
        if (kind == 5 || kind == 6) begin
            c.ball = 1'b1;
        end else if (kind == 7) begin
            c.mode = 3'($urandom_range(MODE_VIEW_LEFT, MODE_HOME));
        end else if (kind == 8) begin
            c.mode     = 3'($urandom_range(0, 7));
            c.ball     = 1'($urandom_range(0, 1));
            c.cap_done = 1'($urandom_range(0, 1));
            c.stamp    = $urandom;
        end else if (kind == 9) begin
            c.ball = 1'($urandom_range(0, 1));
        end
        return c;
    endfunction

    task automatic run_random_calls(input int n);
        int done_calls;
        int run_len;
        int kind;
        done_calls = 0;
        while (done_calls < n) begin
            kind    = $urandom_range(0, 9);
            run_len = $urandom_range(1, 8);
            // occasional stretch where neither side idles
            no_idle = ($urandom_range(0, 5) == 0);
            for (int k = 0; k < run_len && done_calls < n; k++) begin
                issue_call(random_call(kind));
                done_calls++;
            end
        end
        no_idle = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // dwell timer: arming call, boundary not exceeded, capture wait, time wrap
    task automatic test_dwell_timing();
        issue_call(make_call(MODE_SCAN, 1'b0, 1'b1, 9'd0, 8'd0, 32'd1000));
        issue_call(make_call(MODE_SCAN, 1'b0, 1'b1, 9'd0, 8'd0, 32'd1500));
        issue_call(make_call(MODE_SCAN, 1'b0, 1'b0, 9'd0, 8'd0, 32'd1501));
        issue_call(make_call(MODE_SCAN, 1'b0, 1'b1, 9'd0, 8'd0, 32'd2002));
        issue_call(make_call(MODE_SCAN, 1'b0, 1'b1, 9'd0, 8'd0, 32'hFFFF_FF00));
        issue_call(make_call(MODE_SCAN, 1'b0, 1'b1, 9'd0, 8'd0, 32'h0000_0100));
    endtask

    // ball at the image corners, dead center and both deadband edges
    task automatic test_tracking_extremes();
        issue_call(make_call(MODE_SCAN, 1'b1, 1'b0, 9'd0,   8'd0,   32'd3000));
        issue_call(make_call(MODE_SCAN, 1'b1, 1'b1, 9'd319, 8'd239, 32'hFFFF_FFFF));
        issue_call(make_call(MODE_SCAN, 1'b1, 1'b0, 9'd160, 8'd120, 32'd0));
        issue_call(make_call(MODE_SCAN, 1'b1, 1'b0, 9'd175, 8'd0,   32'd10));
        issue_call(make_call(MODE_SCAN, 1'b1, 1'b0, 9'd176, 8'd239, 32'd20));
        issue_call(make_call(MODE_SCAN, 1'b1, 1'b0, 9'd145, 8'd120, 32'd30));
        issue_call(make_call(MODE_SCAN, 1'b1, 1'b0, 9'd144, 8'd51,  32'd40));
    endtask

    // every fixed view, home, the two unused codes, then scan restarts
    task automatic test_views_and_home();
        issue_call(make_call(MODE_VIEW_LEFT,  1'b1, 1'b1, 9'd300, 8'd10, 32'd50));
        issue_call(make_call(MODE_VIEW_RIGHT, 1'b0, 1'b0, 9'd0,   8'd0,  32'd60));
        issue_call(make_call(MODE_VIEW_DOWN,  1'b0, 1'b0, 9'd0,   8'd0,  32'd70));
        issue_call(make_call(MODE_KICK_VIEW,  1'b0, 1'b1, 9'd0,   8'd0,  32'd80));
        issue_call(make_call(MODE_RSVD6,      1'b1, 1'b1, 9'd10,  8'd10, 32'd90));
        issue_call(make_call(MODE_HOME,       1'b0, 1'b0, 9'd0,   8'd0,  32'd100));
        issue_call(make_call(MODE_RSVD7,      1'b0, 1'b1, 9'd0,   8'd0,  32'd110));
        issue_call(make_call(MODE_SCAN,       1'b0, 1'b1, 9'd0,   8'd0,  32'd120));
    endtask

    // widest range and fully crossed limits, both saturation ends
    task automatic test_config_extremes();
        load_setting('{pan_center: 10'd1023, pan_left_limit: 10'd0,
                       pan_right_limit: 10'd1023, tilt_top_limit: 10'd0,
                       tilt_bottom_limit: 10'd1023, dwell_ms: 16'hFFFF,
                       tilt_servo_id: 8'd253, pan_servo_id: 8'd0});
        run_random_calls(EXTREME_CALLS);
        load_setting('{pan_center: 10'd0, pan_left_limit: 10'd1023,
                       pan_right_limit: 10'd0, tilt_top_limit: 10'd1023,
                       tilt_bottom_limit: 10'd0, dwell_ms: 16'd0,
                       tilt_servo_id: 8'd0, pan_servo_id: 8'd253});
        run_random_calls(EXTREME_CALLS);
    endtask

    task automatic test_random_calls();
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            load_setting(random_setting());
            clock_ms = $urandom;
            run_random_calls(CALLS_PER_PHASE);
        end
    endtask

    task automatic finish_run();
        drain_packets();
        // catch any stray bytes after the last packet
        repeat (TAIL_CYCLES) @(posedge aclk);
        $display("run: %0d control calls, %0d packet bytes, %0d register writes",
                 calls_sent, bytes_seen, reg_writes);
        $display("scan steps 7..1 visited: %b, tracking, views, home and idle codes",
                 steps_seen[7:1]);
        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    endtask

    // ------------------------------------------------------------------
    // sequencing
    // ------------------------------------------------------------------

    initial begin
        aresetn        = 1'b0;
        cfg_valid      = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        s_valid        = 1'b0;
        s_mode         = '0;
        s_ball_found   = 1'b0;
        s_capture_done = 1'b0;
        s_ball_x       = '0;
        s_ball_y       = '0;
        s_time_ms      = '0;
        no_idle        = 1'b0;
        steps_seen     = '0;
        clock_ms       = '0;
        errors         = 0;
        calls_sent     = 0;
        bytes_seen     = 0;
        reg_writes     = 0;
        reset_head_model();
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        test_dwell_timing();
        test_tracking_extremes();
        test_views_and_home();
        test_config_extremes();
        test_random_calls();
        finish_run();
    end

    // packet receiver: random stall before each byte
    initial begin : byte_sink
        int stall;
        m_ready = 1'b0;
        while (aresetn !== 1'b1) @(posedge aclk);
        forever begin
            stall = pick_gap();
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    // compare every accepted byte with the oldest owed one
    always @(posedge aclk) begin : byte_check
        packet_byte_t want;
        if (aresetn && m_valid && m_ready) begin
            bytes_seen++;
            if (expected_bytes.size() == 0) begin
                $error("packet byte %h with no call pending", m_packet_byte);
                errors++;
            end else begin
                want = expected_bytes.pop_front();
                if (m_packet_byte !== want.data) begin
                    $error("packet_byte: expected %h, got %h", want.data, m_packet_byte);
                    errors++;
                end
                if (m_last_byte !== want.last) begin
                    $error("last_byte: expected %b, got %b", want.last, m_last_byte);
                    errors++;
                end
                if (m_capture_request !== want.capture) begin
                    $error("capture_request: expected %b, got %b",
                           want.capture, m_capture_request);
                    errors++;
                end
            end
        end
    end

    // give up when no request moves on any channel for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)
                || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no request moved for %0d cycles, %0d bytes still owed",
                     WATCHDOG_LIMIT, expected_bytes.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

endmodule
